// ===== rtl/hwd_pkg.sv =====
`timescale 1ns / 1ps

package hwd_pkg;

    // Defaults for the top-level parameters.
    localparam int TABLE_SLOTS_DEF = 4096;
    localparam int MAX_WORDS_DEF   = 2048;
    localparam int WORD_BYTES_DEF  = 15;

    // Fixed field widths.
    localparam int HEAD_W   = 64;
    localparam int TAIL_W   = 56;
    localparam int WORD_W   = HEAD_W + TAIL_W;
    localparam int LEN_W    = 4;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 11;
    localparam int HASH_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int MAX_BYTES = WORD_W / BYTE_W;

    localparam logic [HASH_W-1:0] HASH_MUL = 32'd31;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_SUCCESS   = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RES_INSERTED  = 2'd0,
        RES_FOUND     = 2'd1,
        RES_NOT_FOUND = 2'd2,
        RES_FULL      = 2'd3
    } res_code_t;

    typedef struct packed {
        logic      load_item;
        logic      hash_step;
        logic      finish_hash;
        logic      clear_step;
        logic      advance;
        logic      insert;
        logic      res_set;
        res_code_t res_code;
        logic      load_out;
    } hwd_cmd_t;

    typedef struct packed {
        logic hash_done;
        logic lookup;
        logic full;
        logic used;
        logic match;
        logic probe_last;
        logic clear_last;
    } hwd_stat_t;

endpackage

// ===== rtl/hwd_datapath.sv =====
`timescale 1ns / 1ps

module hwd_datapath #(
    parameter int TABLE_SLOTS = hwd_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_WORDS   = hwd_pkg::MAX_WORDS_DEF,
    parameter int WORD_BYTES  = hwd_pkg::WORD_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hwd_pkg::hwd_cmd_t             cmd,
    output hwd_pkg::hwd_stat_t            stat,
    input  logic                          opcode,
    input  logic [hwd_pkg::HEAD_W-1:0]    word_head,
    input  logic [hwd_pkg::TAIL_W-1:0]    word_tail,
    input  logic [hwd_pkg::LEN_W-1:0]     word_length,
    output logic [hwd_pkg::STATUS_W-1:0]  status,
    output logic [hwd_pkg::INDEX_W-1:0]   entry_index
);

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int IDX_W   = $clog2(MAX_WORDS);
    localparam int CNT_W   = $clog2(MAX_WORDS + 1);
    localparam int SLOT_DW = IDX_W + 1;
    localparam int WORD_W  = hwd_pkg::WORD_W;
    localparam int PAD_W   = (hwd_pkg::MAX_BYTES + 1) * hwd_pkg::BYTE_W;
    localparam int EXT_W   = IDX_W + hwd_pkg::INDEX_W;

    // Slot entry: used flag on top, word index below.
    logic [SLOT_DW-1:0] slot_mem [TABLE_SLOTS];
    logic [WORD_W-1:0]  word_mem [MAX_WORDS];

    logic [SLOT_DW-1:0]          slot_q_reg;
    logic [WORD_W-1:0]           word_q_reg;
    logic [WORD_W-1:0]           word_reg, word_next;
    logic                        op_reg;
    logic [hwd_pkg::LEN_W-1:0]   len_reg;
    logic [hwd_pkg::LEN_W-1:0]   byte_idx_reg;
    logic [hwd_pkg::HASH_W-1:0]  hash_reg;
    logic [SLOT_W-1:0]           probe_slot_reg;
    logic [SLOT_W-1:0]           probe_cnt_reg;
    logic [CNT_W-1:0]            entry_count_reg;
    hwd_pkg::status_t            res_status_reg;
    logic [IDX_W-1:0]            res_index_reg;
    logic [hwd_pkg::STATUS_W-1:0] out_status_reg;
    logic [hwd_pkg::INDEX_W-1:0] out_index_reg;

    logic [PAD_W-1:0]            word_pad;
    logic [hwd_pkg::BYTE_W-1:0]  cur_byte;
    logic [hwd_pkg::LEN_W-1:0]   len_eff;
    logic                        slot_we;
    logic [SLOT_DW-1:0]          slot_wdata;
    logic [IDX_W-1:0]            entry_idx;
    logic [IDX_W-1:0]            slot_idx;
    logic [EXT_W-1:0]            index_ext;

    assign word_pad  = {{(PAD_W - WORD_W){1'b0}}, word_reg};
    assign cur_byte  = word_pad[{byte_idx_reg, 3'b000} +: hwd_pkg::BYTE_W];
    assign len_eff   = (word_length > hwd_pkg::LEN_W'(WORD_BYTES))
                       ? hwd_pkg::LEN_W'(WORD_BYTES) : word_length;
    assign entry_idx = entry_count_reg[IDX_W-1:0];
    assign slot_idx  = slot_q_reg[IDX_W-1:0];

    // Bytes from the stopping point onwards are cleared when hashing ends.
    always_comb
    begin
        for (int k = 0; k < hwd_pkg::MAX_BYTES; k++)
        begin
            word_next[k*hwd_pkg::BYTE_W +: hwd_pkg::BYTE_W] =
                (hwd_pkg::LEN_W'(k) < byte_idx_reg)
                ? word_reg[k*hwd_pkg::BYTE_W +: hwd_pkg::BYTE_W]
                : '0;
        end
    end

    always_comb
    begin
        stat.hash_done  = (byte_idx_reg >= len_reg) || (cur_byte == '0);
        stat.lookup     = (op_reg == hwd_pkg::OP_LOOKUP);
        stat.full       = (entry_count_reg == CNT_W'(MAX_WORDS));
        stat.used       = slot_q_reg[SLOT_DW-1];
        stat.match      = (word_q_reg == word_reg);
        stat.probe_last = &probe_cnt_reg;
        stat.clear_last = &probe_slot_reg;
    end

    assign slot_we    = cmd.clear_step | cmd.insert;
    assign slot_wdata = cmd.insert ? {1'b1, entry_idx} : '0;

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[probe_slot_reg] <= slot_wdata;
        end
        slot_q_reg <= slot_mem[probe_slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            word_mem[entry_idx] <= word_reg;
        end
        word_q_reg <= word_mem[slot_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_slot_reg  <= '0;
            entry_count_reg <= '0;
        end
        else
        begin
            if (cmd.clear_step || cmd.advance)
            begin
                probe_slot_reg <= probe_slot_reg + 1'b1;
            end
            else if (cmd.finish_hash)
            begin
                probe_slot_reg <= hash_reg[SLOT_W-1:0];
            end
            if (cmd.insert)
            begin
                entry_count_reg <= entry_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            word_reg     <= {word_tail, word_head};
            op_reg       <= opcode;
            len_reg      <= len_eff;
            byte_idx_reg <= '0;
            hash_reg     <= '0;
        end
        else if (cmd.hash_step)
        begin
            hash_reg     <= hash_reg * hwd_pkg::HASH_MUL + hwd_pkg::HASH_W'(cur_byte);
            byte_idx_reg <= byte_idx_reg + 1'b1;
        end
        else if (cmd.finish_hash)
        begin
            word_reg <= word_next;
        end

        if (cmd.finish_hash)
        begin
            probe_cnt_reg <= '0;
        end
        else if (cmd.advance)
        begin
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
        end

        if (cmd.res_set)
        begin
            unique case (cmd.res_code)
                hwd_pkg::RES_INSERTED:
                begin
                    res_status_reg <= hwd_pkg::ST_SUCCESS;
                    res_index_reg  <= entry_idx;
                end
                hwd_pkg::RES_FOUND:
                begin
                    res_status_reg <= hwd_pkg::ST_SUCCESS;
                    res_index_reg  <= slot_idx;
                end
                hwd_pkg::RES_NOT_FOUND:
                begin
                    res_status_reg <= hwd_pkg::ST_NOT_FOUND;
                    res_index_reg  <= '0;
                end
                hwd_pkg::RES_FULL:
                begin
                    res_status_reg <= hwd_pkg::ST_FULL;
                    res_index_reg  <= '0;
                end
            endcase
        end

        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= index_ext[hwd_pkg::INDEX_W-1:0];
        end
    end

    assign index_ext   = {{hwd_pkg::INDEX_W{1'b0}}, res_index_reg};
    assign status      = out_status_reg;
    assign entry_index = out_index_reg;

endmodule

// ===== rtl/hwd_controller.sv =====
`timescale 1ns / 1ps

module hwd_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  hwd_pkg::hwd_stat_t  stat,
    output hwd_pkg::hwd_cmd_t   cmd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_HASH   = 7'b0000100,
        S_READ   = 7'b0001000,
        S_CHECK  = 7'b0010000,
        S_CMP    = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.res_code   = hwd_pkg::RES_NOT_FOUND;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_HASH;
                end
            end
            S_HASH:
            begin
                if (!stat.hash_done)
                begin
                    cmd.hash_step = 1'b1;
                end
                else
                begin
                    cmd.finish_hash = 1'b1;
                    if (!stat.lookup && stat.full)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = hwd_pkg::RES_FULL;
                        state_next   = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                priority if (!stat.used)
                begin
                    cmd.res_set = 1'b1;
                    if (stat.lookup)
                    begin
                        cmd.res_code = hwd_pkg::RES_NOT_FOUND;
                    end
                    else
                    begin
                        cmd.insert   = 1'b1;
                        cmd.res_code = hwd_pkg::RES_INSERTED;
                    end
                    state_next = S_RESULT;
                end
                else if (stat.lookup)
                begin
                    state_next = S_CMP;
                end
                else if (stat.probe_last)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = hwd_pkg::RES_FULL;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_CMP:
            begin
                priority if (stat.match)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = hwd_pkg::RES_FOUND;
                    state_next   = S_RESULT;
                end
                else if (stat.probe_last)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = hwd_pkg::RES_NOT_FOUND;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_RESULT:
            begin
                // Wait here only while the previous result is still unclaimed.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/hashed_word_dictionary.sv =====
`timescale 1ns / 1ps
// Sequence: the hash steps through the bytes of the word, then the word's unused bytes are
// cleared; each slot probed is read and checked (a lookup also compares the stored word),
// and the result is then loaded into the output register.
// Flow: one item at a time; the next item is accepted the cycle after the result is
// loaded, and the load waits while the previous result is still unclaimed.
// Reset: a clearing pass marks every slot empty, with in_ready low.

module hashed_word_dictionary #(
    parameter int TABLE_SLOTS = hwd_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_WORDS   = hwd_pkg::MAX_WORDS_DEF,
    parameter int WORD_BYTES  = hwd_pkg::WORD_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [hwd_pkg::HEAD_W-1:0]    word_head,
    input  logic [hwd_pkg::TAIL_W-1:0]    word_tail,
    input  logic [hwd_pkg::LEN_W-1:0]     word_length,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hwd_pkg::STATUS_W-1:0]  status,
    output logic [hwd_pkg::INDEX_W-1:0]   entry_index
);

    hwd_pkg::hwd_cmd_t  cmd;
    hwd_pkg::hwd_stat_t stat;

    hwd_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hwd_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .MAX_WORDS   (MAX_WORDS),
        .WORD_BYTES  (WORD_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .word_head   (word_head),
        .word_tail   (word_tail),
        .word_length (word_length),
        .status      (status),
        .entry_index (entry_index)
    );

endmodule
